>>> rtl/erm_pkg.sv
// Shared constants and the CORDIC arctangent table for the rotation matrix core.
package erm_pkg;

    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
    localparam int          CORDIC_ITERS = 30;
    localparam int          CW           = 34;   // CORDIC datapath width, Q30 plus headroom
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [63:0] PI30_U  = (PI_Q60 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] HPI30_U = (PI_Q60 + (64'd1 << 30)) >> 31;
    localparam logic signed [CW-1:0] PI30  = $signed(PI30_U[CW-1:0]);
    localparam logic signed [CW-1:0] HPI30 = $signed(HPI30_U[CW-1:0]);

    typedef logic signed [CW-1:0] t_cw;

    // atan(2^-i) in Q30, rounded to nearest
    function automatic t_cw atan_q30(input int i);
        t_cw v;
        case (i)
            0:       v = 34'sd843314857;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043837;
            3:       v = 34'sd133525159;
            4:       v = 34'sd67021687;
            5:       v = 34'sd33543516;
            6:       v = 34'sd16775851;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194283;
            9:       v = 34'sd2097149;
            default: v = t_cw'(34'sd1 <<< (30 - i));
        endcase
        return v;
    endfunction

endpackage

>>> rtl/euler_rotation_matrix_core.sv
// Top level: Z-Y-X Euler angle rotation matrix, three CORDIC lanes and a merge stage.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------
//  angles   | i_valid / o_ready   | i_angle_x, i_angle_y, i_angle_z (Q3.13)
//  matrix   | o_valid / i_ready   | o_m00 .. o_m22, row major (Q1.14)
//
// One angle triple transfer per cycle, sustained while i_ready does not stall.
// Stages: one range-reduction stage, 30 CORDIC iteration stages, one rounding stage
// in each lane, then three stages of the product/merge array.
// Reset clears only the pipeline valid bits; data registers are not reset.
// The whole pipeline advances when the output is empty or taken; a stall on
// i_ready freezes every stage, and o_ready drops with it.
module euler_rotation_matrix_core #(
    parameter int ANGLE_BITS = 16,
    parameter int COEF_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [ANGLE_BITS-1:0] i_angle_x,
    input  logic signed [ANGLE_BITS-1:0] i_angle_y,
    input  logic signed [ANGLE_BITS-1:0] i_angle_z,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COEF_BITS-1:0]  o_m00, o_m01, o_m02,
    output logic signed [COEF_BITS-1:0]  o_m10, o_m11, o_m12,
    output logic signed [COEF_BITS-1:0]  o_m20, o_m21, o_m22
);
    import erm_pkg::*;

    localparam int LAT = CORDIC_ITERS + 2 + 3;

    logic [LAT-1:0] r_vld, n_vld;
    logic en;

    // pipeline moves unless the finished result is held back
    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    assign n_vld = {r_vld[LAT-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    logic signed [COEF_BITS-1:0] sx, cx, sy, cy, sz, cz;
    logic signed [COEF_BITS-1:0] m [9];

    erm_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_lane_x (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_x), .o_sin(sx), .o_cos(cx));
    erm_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_lane_y (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_y), .o_sin(sy), .o_cos(cy));
    erm_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .COEF_BITS(COEF_BITS)) u_lane_z (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_z), .o_sin(sz), .o_cos(cz));

    erm_matrix #(.COEF_BITS(COEF_BITS)) u_matrix (
        .i_clk(i_clk), .i_en(en),
        .i_sx(sx), .i_cx(cx), .i_sy(sy), .i_cy(cy), .i_sz(sz), .i_cz(cz),
        .o_m(m));

    assign o_m00 = m[0];
    assign o_m01 = m[1];
    assign o_m02 = m[2];
    assign o_m10 = m[3];
    assign o_m11 = m[4];
    assign o_m12 = m[5];
    assign o_m20 = m[6];
    assign o_m21 = m[7];
    assign o_m22 = m[8];

    localparam logic signed [COEF_BITS-1:0] ONE_C = COEF_BITS'(1) <<< (COEF_BITS - 2);

    a_m00_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_m00 <= ONE_C && o_m00 >= -ONE_C))
        else $error("m00 out of unit range");
    a_m22_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_m22 <= ONE_C && o_m22 >= -ONE_C))
        else $error("m22 out of unit range");
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_m11)))
        else $error("result lost during stall");

endmodule

>>> rtl/erm_cordic_lane.sv
// One pipelined rotation-mode CORDIC lane: angle in, sine and cosine out.
module erm_cordic_lane #(
    parameter int ANGLE_BITS = 16,
    parameter int COEF_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [ANGLE_BITS-1:0] i_angle,
    output logic signed [COEF_BITS-1:0]  o_sin,
    output logic signed [COEF_BITS-1:0]  o_cos
);
    import erm_pkg::*;

    localparam logic [63:0] PLIM_U =
        (PI_Q60 + (64'd1 << (62 - ANGLE_BITS))) >> (63 - ANGLE_BITS);
    localparam logic signed [ANGLE_BITS:0] PLIM = $signed(PLIM_U[ANGLE_BITS:0]);
    localparam int SH = 30 - (COEF_BITS - 2);
    localparam t_cw ONE = t_cw'(34'sd1 <<< (COEF_BITS - 2));
    localparam t_cw HALF = t_cw'(34'sd1 <<< (SH - 1));

    t_cw  r_x [CORDIC_ITERS+1];
    t_cw  r_y [CORDIC_ITERS+1];
    t_cw  r_z [CORDIC_ITERS+1];
    logic r_neg [CORDIC_ITERS+1];

    logic signed [ANGLE_BITS:0] a_sat;
    t_cw z_full;

    always_comb begin
        a_sat = {i_angle[ANGLE_BITS-1], i_angle};
        if (a_sat > PLIM) begin
            a_sat = PLIM;
        end else if (a_sat < -PLIM) begin
            a_sat = -PLIM;
        end
        z_full = t_cw'(a_sat) <<< (33 - ANGLE_BITS);
    end

    // range reduction to [-pi/2, pi/2]
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            if (z_full > HPI30) begin
                r_z[0]   <= z_full - PI30;
                r_neg[0] <= 1'b1;
            end else if (z_full < -HPI30) begin
                r_z[0]   <= z_full + PI30;
                r_neg[0] <= 1'b1;
            end else begin
                r_z[0]   <= z_full;
                r_neg[0] <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(g);
                end
            end
        end
    end

    t_cw xf, yf, xr, yr;

    always_comb begin
        xf = r_neg[CORDIC_ITERS] ? -r_x[CORDIC_ITERS] : r_x[CORDIC_ITERS];
        yf = r_neg[CORDIC_ITERS] ? -r_y[CORDIC_ITERS] : r_y[CORDIC_ITERS];
        xr = (xf + HALF) >>> SH;
        yr = (yf + HALF) >>> SH;
        if (xr > ONE) xr = ONE;
        if (xr < -ONE) xr = -ONE;
        if (yr > ONE) yr = ONE;
        if (yr < -ONE) yr = -ONE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= xr[COEF_BITS-1:0];
            o_sin <= yr[COEF_BITS-1:0];
        end
    end

endmodule

>>> rtl/erm_matrix.sv
// Merge stage: combines the three lanes' sines and cosines into the matrix.
module erm_matrix #(
    parameter int COEF_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [COEF_BITS-1:0] i_sx, i_cx, i_sy, i_cy, i_sz, i_cz,
    output logic signed [COEF_BITS-1:0] o_m [9]
);
    localparam int C  = COEF_BITS;
    localparam int F  = C - 2;
    localparam int PW = 2 * C + 1;
    typedef logic signed [PW-1:0] t_p;
    typedef logic signed [C-1:0]  t_c;

    function automatic t_c fin(input t_p w);
        t_p r;
        r = (w + (t_p'(1) <<< (F - 1))) >>> F;
        if (r > (t_p'(1) <<< F)) r = t_p'(1) <<< F;
        if (r < -(t_p'(1) <<< F)) r = -(t_p'(1) <<< F);
        return r[C-1:0];
    endfunction

    // stage 1: sy*sx and sy*cx rounded
    t_c r_t1, r_t2, r_sx, r_cx, r_sy, r_cy, r_sz, r_cz;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1 <= fin(t_p'(i_sy) * t_p'(i_sx));
            r_t2 <= fin(t_p'(i_sy) * t_p'(i_cx));
            r_sx <= i_sx; r_cx <= i_cx; r_sy <= i_sy;
            r_cy <= i_cy; r_sz <= i_sz; r_cz <= i_cz;
        end
    end

    // stage 2: products
    t_p r_p [12];
    t_c r_nsy;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]  <= t_p'(r_cz) * t_p'(r_cy);
            r_p[1]  <= t_p'(r_cz) * t_p'(r_t1);
            r_p[2]  <= t_p'(r_sz) * t_p'(r_cx);
            r_p[3]  <= t_p'(r_cz) * t_p'(r_t2);
            r_p[4]  <= t_p'(r_sz) * t_p'(r_sx);
            r_p[5]  <= t_p'(r_sz) * t_p'(r_cy);
            r_p[6]  <= t_p'(r_sz) * t_p'(r_t1);
            r_p[7]  <= t_p'(r_cz) * t_p'(r_cx);
            r_p[8]  <= t_p'(r_sz) * t_p'(r_t2);
            r_p[9]  <= t_p'(r_cz) * t_p'(r_sx);
            r_p[10] <= t_p'(r_cy) * t_p'(r_sx);
            r_p[11] <= t_p'(r_cy) * t_p'(r_cx);
            r_nsy   <= -r_sy;
        end
    end

    // stage 3: sums, round, clamp
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_m[0] <= fin(r_p[0]);
            o_m[1] <= fin(r_p[1] - r_p[2]);
            o_m[2] <= fin(r_p[3] + r_p[4]);
            o_m[3] <= fin(r_p[5]);
            o_m[4] <= fin(r_p[6] + r_p[7]);
            o_m[5] <= fin(r_p[8] - r_p[9]);
            o_m[6] <= r_nsy;
            o_m[7] <= fin(r_p[10]);
            o_m[8] <= fin(r_p[11]);
        end
    end

endmodule
